/* src/baes_pkg.sv */
// Shared types, codes and the microcode store of the advertiser event sequencer.
package baes_pkg;

   // Fixed widths of the request and response fields.
   localparam int KIND_W    = 3;
   localparam int PTYPE_W   = 4;
   localparam int LEN_W     = 8;
   localparam int ADDR_W    = 48;
   localparam int TIME_W    = 32;
   localparam int RND_W     = 8;
   localparam int ACTION_W  = 3;
   localparam int CHAN_W    = 6;
   localparam int STATE_W   = 2;
   localparam int COUNT_W   = 2;
   localparam int TABLE_W   = 18;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 48;

   // Highest number of advertising channels used in one event.
   localparam logic [COUNT_W-1:0] MAX_CHANNELS = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ADV_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_TABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDRESS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ADV_PERIOD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_STEP     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME    = 3'd6;

   // Event kinds.
   localparam logic [KIND_W-1:0] KIND_START      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STOP       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CANCELED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PASSED     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TX_DONE    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RX_DONE    = 3'd5;

   // Radio actions.
   localparam logic [ACTION_W-1:0] ACT_NONE   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ADV    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_LISTEN = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RSP    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd4;

   // Advertising modes that matter for listening and responding.
   localparam logic [MODE_W-1:0] MODE_CONN_SCAN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SCAN      = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONCONN   = 2'd3;

   // Scan request recognition.
   localparam logic [PTYPE_W-1:0] PDU_SCAN_REQ = 4'd3;
   localparam logic [LEN_W-1:0]   SCAN_REQ_LEN = 8'd12;

   // Random delay: 30 time units times (random byte with the low nibble forced to ones).
   localparam logic [RND_W-1:0] RND_FLOOR = 8'h0f;
   localparam int DELAY_W = 13;

   // Advertiser state, one-hot inside the block.
   typedef enum logic [3:0] {
      ADV_IDLE      = 4'b0001,
      ADV_SEND_ADV  = 4'b0010,
      ADV_SEND_RSP  = 4'b0100,
      ADV_RECEIVING = 4'b1000
   } adv_state_type;

   // Encoded state values on the response.
   localparam logic [STATE_W-1:0] CODE_IDLE      = 2'd0;
   localparam logic [STATE_W-1:0] CODE_SEND_ADV  = 2'd1;
   localparam logic [STATE_W-1:0] CODE_SEND_RSP  = 2'd2;
   localparam logic [STATE_W-1:0] CODE_RECEIVING = 2'd3;

   // Divider iterations for a 32-bit quotient.
   localparam int DIV_CNT_W = $clog2(TIME_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TIME_W - 1);

   // Microprogram addresses.
   typedef logic [3:0] upc_type;
   localparam upc_type UPC_FETCH    = 4'd0;
   localparam upc_type UPC_STOP     = 4'd1;
   localparam upc_type UPC_FSM      = 4'd2;
   localparam upc_type UPC_DIV_INIT = 4'd3;
   localparam upc_type UPC_DIV_STEP = 4'd4;
   localparam upc_type UPC_MUL      = 4'd5;
   localparam upc_type UPC_ADD_PROD = 4'd6;
   localparam upc_type UPC_ADD_PER  = 4'd7;
   localparam upc_type UPC_RESP     = 4'd8;

   // Datapath operation of one control word.
   typedef enum logic [3:0] {
      OP_ACCEPT   = 4'd0,
      OP_SLOT     = 4'd1,
      OP_FSM      = 4'd2,
      OP_DIV_INIT = 4'd3,
      OP_DIV_STEP = 4'd4,
      OP_MUL      = 4'd5,
      OP_ADD_PROD = 4'd6,
      OP_ADD_PER  = 4'd7,
      OP_RESP     = 4'd8,
      OP_NOP      = 4'd9
   } op_type;

   // Sequencing condition of one control word.
   typedef enum logic [2:0] {
      COND_NEXT     = 3'd0,
      COND_GOTO     = 3'd1,
      COND_LOOP     = 3'd2,
      COND_DISPATCH = 3'd3,
      COND_WAIT_OUT = 3'd4
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } uword_type;

   // The microprogram.
   function automatic uword_type ucode_rom(input upc_type addr);
      uword_type w;
      unique case (addr)
         UPC_FETCH:    w = '{op: OP_ACCEPT,   cond: COND_DISPATCH, target: UPC_FETCH};
         UPC_STOP:     w = '{op: OP_SLOT,     cond: COND_GOTO,     target: UPC_RESP};
         UPC_FSM:      w = '{op: OP_FSM,      cond: COND_GOTO,     target: UPC_RESP};
         UPC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEXT,     target: UPC_FETCH};
         UPC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_LOOP,     target: UPC_DIV_STEP};
         UPC_MUL:      w = '{op: OP_MUL,      cond: COND_NEXT,     target: UPC_FETCH};
         UPC_ADD_PROD: w = '{op: OP_ADD_PROD, cond: COND_NEXT,     target: UPC_FETCH};
         UPC_ADD_PER:  w = '{op: OP_ADD_PER,  cond: COND_NEXT,     target: UPC_FETCH};
         UPC_RESP:     w = '{op: OP_RESP,     cond: COND_WAIT_OUT, target: UPC_FETCH};
         default:      w = '{op: OP_NOP,      cond: COND_GOTO,     target: UPC_FETCH};
      endcase
      return w;
   endfunction

   // One-hot state to the encoded value on the response.
   function automatic logic [STATE_W-1:0] state_code(input adv_state_type s);
      logic [STATE_W-1:0] c;
      unique case (s)
         ADV_IDLE:      c = CODE_IDLE;
         ADV_SEND_ADV:  c = CODE_SEND_ADV;
         ADV_SEND_RSP:  c = CODE_SEND_RSP;
         ADV_RECEIVING: c = CODE_RECEIVING;
         default:       c = CODE_IDLE;
      endcase
      return c;
   endfunction

endpackage

/* src/baes_if.sv */
// Request and response channel interfaces of the advertiser event sequencer.
interface baes_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [3:0]  rx_pdu_type;
   logic [7:0]  rx_length;
   logic [47:0] rx_target_address;
   logic [31:0] now_time;
   logic [7:0]  random_value;

   modport source (
      output valid, kind, rx_pdu_type, rx_length, rx_target_address, now_time, random_value,
      input  ready
   );
   modport sink (
      input  valid, kind, rx_pdu_type, rx_length, rx_target_address, now_time, random_value,
      output ready
   );
endinterface

interface baes_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [5:0]  channel;
   logic [1:0]  new_state;
   logic [31:0] next_time;

   modport source (
      output valid, action, channel, new_state, next_time,
      input  ready
   );
   modport sink (
      input  valid, action, channel, new_state, next_time,
      output ready
   );
endinterface

/* src/ble_advertiser_event_sequencer_unit.sv */
// Top level of the advertiser event sequencer: microcoded control and its datapath.
//
// Usage: every scheduler or radio event enters as one request on req_chan and gives exactly
// one response on rsp_chan (radio action, channel, new advertiser state, next event time).
// Configuration registers are written through csr_we / csr_index / csr_wdata while no
// request is in flight; writing start_time also loads the event time.
// Control is a nine-word microprogram; the step counter walks it, one control word per
// cycle. A request is taken only at the fetch step, so one request is in flight at a time.
// Stop events pass through the slot step, the other events that do not realign through the
// state-machine step; both then reach the response step, which loads the response and returns
// to the fetch step. Canceled and passed events taken while idle realign the event time to the
// next whole period; the restoring divider takes one quotient bit per cycle, and that path runs
// through setup, 32 divide steps, one multiply, two adds and the response load.
// The response sits in an output register. The next request is accepted while a response
// still waits; only when a second response is ready and the first is still not taken does
// the sequencer hold at its response step until rsp_chan.ready is seen.
// Reset (synchronous, active high) returns the sequencer to its fetch step, clears the
// response valid, sets the advertiser idle, clears the instant counter and channel, loads
// the channels left with three and the event time with zero, and sets register defaults.
module ble_advertiser_event_sequencer_unit
   import baes_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   baes_req_if.sink             req_chan,
   baes_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   // Sequencer.
   upc_type                upc_ff, upc_in;
   uword_type              uword;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   // Configuration registers.
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [COUNT_W-1:0]     ccount_ff, ccount_in;
   logic [TABLE_W-1:0]     table_ff, table_in;
   logic [ADDR_W-1:0]      own_ff, own_in;
   logic [TIME_W-1:0]      period_ff, period_in;
   logic [TIME_W-1:0]      step_ff, step_in;

   // Advertiser state.
   adv_state_type          adv_state_ff, adv_state_in;
   logic [TIME_W-1:0]      instant_ff, instant_in;
   logic [1:0]             mod3_ff, mod3_in;
   logic [COUNT_W-1:0]     left_ff, left_in;
   logic [CHAN_W-1:0]      chan_ff, chan_in;
   logic [TIME_W-1:0]      evt_ff, evt_in;

   // Latched request and working registers.
   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic [PTYPE_W-1:0]     ptype_ff, ptype_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [RND_W-1:0]       rnd_ff, rnd_in;
   logic [ACTION_W-1:0]    act_ff, act_in;
   logic [TIME_W-1:0]      num_ff, num_in;
   logic [TIME_W-1:0]      rem_ff, rem_in;
   logic [TIME_W-1:0]      prod_ff, prod_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ACTION_W-1:0]    rsp_action_ff, rsp_action_in;
   logic [CHAN_W-1:0]      rsp_chan_ff, rsp_chan_in;
   logic [STATE_W-1:0]     rsp_state_ff, rsp_state_in;
   logic [TIME_W-1:0]      rsp_time_ff, rsp_time_in;

   // Combinational helpers.
   logic                   req_fire;
   logic                   out_free;
   upc_type                dispatch_target;
   logic [COUNT_W-1:0]     count_eff;
   logic [TIME_W-1:0]      period_eff;
   logic                   can_listen;
   logic                   can_rsp;
   logic [COUNT_W-1:0]     left_dec;
   logic [RND_W-1:0]       rnd_or;
   logic [DELAY_W-1:0]     delay;
   logic [TIME_W:0]        trial;
   logic [1:0]             tbl_idx;
   logic [TIME_W-1:0]      instant_inc;

   assign uword = ucode_rom(upc_ff);

   assign req_chan.ready = (upc_ff == UPC_FETCH);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.action    = rsp_action_ff;
   assign rsp_chan.channel   = rsp_chan_ff;
   assign rsp_chan.new_state = rsp_state_ff;
   assign rsp_chan.next_time = rsp_time_ff;

   // Channel count clamped to 1..MAX_CHANNELS, and a zero period read as one.
   assign count_eff  = (ccount_ff == '0) ? COUNT_W'(1) :
                       (ccount_ff > MAX_CHANNELS) ? MAX_CHANNELS : ccount_ff;
   assign period_eff = (period_ff == '0) ? TIME_W'(1) : period_ff;

   assign can_listen = (mode_ff != MODE_NONCONN);
   assign can_rsp    = (mode_ff == MODE_CONN_SCAN) || (mode_ff == MODE_SCAN);

   // The stop event always wins; realignment only happens from idle.
   always_comb begin
      priority if (req_chan.kind == KIND_STOP) begin
         dispatch_target = UPC_STOP;
      end else if ((adv_state_ff == ADV_IDLE) &&
                   ((req_chan.kind == KIND_CANCELED) || (req_chan.kind == KIND_PASSED))) begin
         dispatch_target = UPC_DIV_INIT;
      end else begin
         dispatch_target = UPC_FSM;
      end
   end

   // 30 * x computed as 32x - 2x.
   assign rnd_or = rnd_ff | RND_FLOOR;
   assign delay  = {rnd_or, 5'b0} - {4'b0, rnd_or, 1'b0};

   assign left_dec = (left_ff == '0) ? '0 : left_ff - COUNT_W'(1);

   // One restoring division step: shift in the next dividend bit and try the divisor.
   assign trial = {rem_ff, num_ff[TIME_W-1]} - {1'b0, period_eff};

   assign instant_inc = instant_ff + TIME_W'(1);

   // Table entry for the new instant: instant mod count, with count at most three.
   always_comb begin
      unique case (count_eff)
         2'd2:    tbl_idx = {1'b0, instant_inc[0]};
         2'd3:    tbl_idx = (instant_inc == '0) ? 2'd0 :
                            (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
         default: tbl_idx = 2'd0;
      endcase
   end

   // Step counter.
   always_comb begin
      unique case (uword.cond)
         COND_NEXT:     upc_in = upc_ff + upc_type'(1);
         COND_GOTO:     upc_in = uword.target;
         COND_LOOP:     upc_in = (cnt_ff != '0) ? uword.target : upc_ff + upc_type'(1);
         COND_DISPATCH: upc_in = req_fire ? dispatch_target : upc_ff;
         COND_WAIT_OUT: upc_in = out_free ? uword.target : upc_ff;
         default:       upc_in = UPC_FETCH;
      endcase
   end

   // Datapath, driven by the operation field of the current control word.
   always_comb begin
      cnt_in       = cnt_ff;
      adv_state_in = adv_state_ff;
      instant_in   = instant_ff;
      mod3_in      = mod3_ff;
      left_in      = left_ff;
      chan_in      = chan_ff;
      evt_in       = evt_ff;
      kind_in      = kind_ff;
      ptype_in     = ptype_ff;
      len_in       = len_ff;
      addr_in      = addr_ff;
      now_in       = now_ff;
      rnd_in       = rnd_ff;
      act_in       = act_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      prod_in      = prod_ff;
      rsp_action_in = rsp_action_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      unique case (uword.op)
         OP_ACCEPT: begin
            if (req_fire) begin
               kind_in  = req_chan.kind;
               ptype_in = req_chan.rx_pdu_type;
               len_in   = req_chan.rx_length;
               addr_in  = req_chan.rx_target_address;
               now_in   = req_chan.now_time;
               rnd_in   = req_chan.random_value;
               act_in   = ACT_NONE;
            end
         end
         OP_SLOT: begin
            act_in       = ACT_STOP;
            adv_state_in = ADV_IDLE;
            if (left_dec != '0) begin
               left_in = left_dec;
               evt_in  = evt_ff + step_ff;
            end else begin
               left_in = count_eff;
               evt_in  = evt_ff + period_ff + TIME_W'(delay);
            end
         end
         OP_FSM: begin
            unique case (adv_state_ff)
               ADV_IDLE: begin
                  if ((kind_ff == KIND_START) && (left_ff != '0)) begin
                     instant_in   = instant_inc;
                     mod3_in      = (instant_inc == '0) ? 2'd0 :
                                    (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
                     chan_in      = table_ff[CHAN_W*tbl_idx +: CHAN_W];
                     act_in       = ACT_ADV;
                     adv_state_in = ADV_SEND_ADV;
                  end
               end
               ADV_SEND_ADV: begin
                  if (kind_ff == KIND_TX_DONE) begin
                     if (can_listen) begin
                        act_in       = ACT_LISTEN;
                        adv_state_in = ADV_RECEIVING;
                     end else begin
                        adv_state_in = ADV_IDLE;
                     end
                  end
               end
               ADV_RECEIVING: begin
                  if (kind_ff == KIND_RX_DONE) begin
                     if (can_rsp && (ptype_ff == PDU_SCAN_REQ) && (len_ff == SCAN_REQ_LEN) &&
                         (addr_ff == own_ff)) begin
                        act_in       = ACT_RSP;
                        adv_state_in = ADV_SEND_RSP;
                     end else begin
                        adv_state_in = ADV_IDLE;
                     end
                  end
               end
               ADV_SEND_RSP: begin
                  if (kind_ff == KIND_TX_DONE) begin
                     adv_state_in = ADV_IDLE;
                  end
               end
               default: adv_state_in = ADV_IDLE;
            endcase
         end
         OP_DIV_INIT: begin
            num_in = now_ff - evt_ff;
            rem_in = '0;
            cnt_in = DIV_LAST;
         end
         OP_DIV_STEP: begin
            if (!trial[TIME_W]) begin
               rem_in = trial[TIME_W-1:0];
               num_in = {num_ff[TIME_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[TIME_W-2:0], num_ff[TIME_W-1]};
               num_in = {num_ff[TIME_W-2:0], 1'b0};
            end
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - DIV_CNT_W'(1);
            end
         end
         OP_MUL: begin
            // (q + 1) * p is done as q * p here and + p in the last add.
            prod_in = num_ff * period_eff;
         end
         OP_ADD_PROD: begin
            evt_in = evt_ff + prod_ff;
         end
         OP_ADD_PER: begin
            evt_in  = evt_ff + period_eff;
            left_in = count_eff;
         end
         OP_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = act_ff;
               rsp_chan_in   = chan_ff;
               rsp_state_in  = state_code(adv_state_ff);
               rsp_time_in   = evt_ff;
            end
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase

      // Configuration writes; start_time also loads the event time.
      if (csr_we && (csr_index == CSR_START_TIME)) begin
         evt_in = csr_wdata[TIME_W-1:0];
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      ccount_in = ccount_ff;
      table_in  = table_ff;
      own_in    = own_ff;
      period_in = period_ff;
      step_in   = step_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ADV_MODE:      mode_in   = csr_wdata[MODE_W-1:0];
            CSR_CHANNEL_COUNT: ccount_in = csr_wdata[COUNT_W-1:0];
            CSR_CHANNEL_TABLE: table_in  = csr_wdata[TABLE_W-1:0];
            CSR_OWN_ADDRESS:   own_in    = csr_wdata[ADDR_W-1:0];
            CSR_ADV_PERIOD:    period_in = csr_wdata[TIME_W-1:0];
            CSR_SLOT_STEP:     step_in   = csr_wdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_FETCH;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= '0;
         ccount_ff    <= 2'd3;
         table_ff     <= '0;
         own_ff       <= '0;
         period_ff    <= TIME_W'(1);
         step_ff      <= '0;
         adv_state_ff <= ADV_IDLE;
         instant_ff   <= '0;
         mod3_ff      <= '0;
         left_ff      <= 2'd3;
         chan_ff      <= '0;
         evt_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         ccount_ff    <= ccount_in;
         table_ff     <= table_in;
         own_ff       <= own_in;
         period_ff    <= period_in;
         step_ff      <= step_in;
         adv_state_ff <= adv_state_in;
         instant_ff   <= instant_in;
         mod3_ff      <= mod3_in;
         left_ff      <= left_in;
         chan_ff      <= chan_in;
         evt_ff       <= evt_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      ptype_ff      <= ptype_in;
      len_ff        <= len_in;
      addr_ff       <= addr_in;
      now_ff        <= now_in;
      rnd_ff        <= rnd_in;
      act_ff        <= act_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      prod_ff       <= prod_in;
      rsp_action_ff <= rsp_action_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_time_ff   <= rsp_time_in;
   end

endmodule

/* tb/baes_response_checker.sv */
// Response checker of the advertiser event sequencer: mirrors its state and compares responses.
module baes_response_checker
   import baes_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   baes_req_if                  req_chan,
   baes_rsp_if                  rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int unsigned          mismatches,
   output int unsigned          outstanding
);

   localparam logic [TIME_W-1:0] DELAY_UNIT   = 32'd30;
   localparam int unsigned       REPORT_LIMIT = 40;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAN_W-1:0]   channel;
      logic [STATE_W-1:0]  new_state;
      logic [TIME_W-1:0]   next_time;
   } sequencer_response_type;

   sequencer_response_type predicted_responses[$];
   int unsigned            fail_total = 0;

   // Register copies.
   logic [MODE_W-1:0]  mode_r;
   logic [COUNT_W-1:0] count_r;
   logic [TABLE_W-1:0] table_r;
   logic [ADDR_W-1:0]  own_addr_r;
   logic [TIME_W-1:0]  period_r;
   logic [TIME_W-1:0]  step_r;
   logic [TIME_W-1:0]  start_r;

   // Sequencer state copies.
   logic [STATE_W-1:0] state_r;
   logic [TIME_W-1:0]  instant_r;
   logic [COUNT_W-1:0] left_r;
   logic [CHAN_W-1:0]  chan_r;
   logic [TIME_W-1:0]  evt_time_r;

   task automatic reset_model();
      mode_r     = MODE_CONN_SCAN;
      count_r    = MAX_CHANNELS;
      table_r    = '0;
      own_addr_r = '0;
      period_r   = 32'd1;
      step_r     = '0;
      start_r    = '0;
      state_r    = CODE_IDLE;
      instant_r  = '0;
      left_r     = MAX_CHANNELS;
      chan_r     = '0;
      evt_time_r = '0;
      predicted_responses.delete();
   endtask

   // Channel count as used for selection and reload: kept inside 1..MAX_CHANNELS.
   function automatic logic [COUNT_W-1:0] clamped_count();
      if (count_r == 0) return 2'd1;
      if (count_r > MAX_CHANNELS) return MAX_CHANNELS;
      return count_r;
   endfunction

   task automatic apply_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      case (idx)
         CSR_ADV_MODE:      mode_r     = data[MODE_W-1:0];
         CSR_CHANNEL_COUNT: count_r    = data[COUNT_W-1:0];
         CSR_CHANNEL_TABLE: table_r    = data[TABLE_W-1:0];
         CSR_OWN_ADDRESS:   own_addr_r = data[ADDR_W-1:0];
         CSR_ADV_PERIOD:    period_r   = data[TIME_W-1:0];
         CSR_SLOT_STEP:     step_r     = data[TIME_W-1:0];
         CSR_START_TIME: begin
            start_r    = data[TIME_W-1:0];
            evt_time_r = data[TIME_W-1:0];
         end
         default: ;
      endcase
   endtask

   function automatic sequencer_response_type advance_sequencer(
      input logic [KIND_W-1:0]  kind,
      input logic [PTYPE_W-1:0] ptype,
      input logic [LEN_W-1:0]   len,
      input logic [ADDR_W-1:0]  addr,
      input logic [TIME_W-1:0]  now,
      input logic [RND_W-1:0]   rnd
   );
      sequencer_response_type r;
      logic [ACTION_W-1:0] act;
      logic                can_listen;
      logic                can_rsp;
      int unsigned         idx;
      logic [TIME_W-1:0]   per;
      logic [TIME_W-1:0]   quot;
      logic [TIME_W-1:0]   delay;
      act        = ACT_NONE;
      can_listen = (mode_r != MODE_NONCONN);
      can_rsp    = (mode_r == MODE_CONN_SCAN) || (mode_r == MODE_SCAN);
      if (kind == KIND_STOP) begin
         act     = ACT_STOP;
         state_r = CODE_IDLE;
         if (left_r != 0) left_r = left_r - 2'd1;
         if (left_r != 0) begin
            evt_time_r = evt_time_r + step_r;
         end else begin
            delay      = DELAY_UNIT * TIME_W'(rnd | RND_FLOOR);
            evt_time_r = evt_time_r + period_r + delay;
            left_r     = clamped_count();
         end
      end else begin
         case (state_r)
            CODE_IDLE: begin
               if (kind == KIND_START) begin
                  if (left_r != 0) begin
                     instant_r = instant_r + 32'd1;
                     idx       = instant_r % clamped_count();
                     chan_r    = table_r[CHAN_W*idx +: CHAN_W];
                     act       = ACT_ADV;
                     state_r   = CODE_SEND_ADV;
                  end
               end else if (kind == KIND_CANCELED || kind == KIND_PASSED) begin
                  // A zero period realigns as if it were one.
                  per        = (period_r == 0) ? 32'd1 : period_r;
                  quot       = (now - evt_time_r) / per;
                  evt_time_r = evt_time_r + (quot + 32'd1) * per;
                  left_r     = clamped_count();
               end
            end
            CODE_SEND_ADV: begin
               if (kind == KIND_TX_DONE) begin
                  if (can_listen) begin
                     act     = ACT_LISTEN;
                     state_r = CODE_RECEIVING;
                  end else begin
                     state_r = CODE_IDLE;
                  end
               end
            end
            CODE_RECEIVING: begin
               if (kind == KIND_RX_DONE) begin
                  if (can_rsp && ptype == PDU_SCAN_REQ && len == SCAN_REQ_LEN &&
                      addr == own_addr_r) begin
                     act     = ACT_RSP;
                     state_r = CODE_SEND_RSP;
                  end else begin
                     state_r = CODE_IDLE;
                  end
               end
            end
            default: begin
               if (kind == KIND_TX_DONE) state_r = CODE_IDLE;
            end
         endcase
      end
      r.action    = act;
      r.channel   = chan_r;
      r.new_state = state_r;
      r.next_time = evt_time_r;
      return r;
   endfunction

   task automatic report_failure(input string msg);
      fail_total++;
      if (fail_total <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [TIME_W-1:0] got,
                                input logic [TIME_W-1:0] want);
      if (got !== want)
         report_failure($sformatf("mismatch on %s: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   task automatic check_response();
      sequencer_response_type want;
      if (predicted_responses.size() == 0) begin
         report_failure("response arrived with no request waiting for one");
      end else begin
         want = predicted_responses.pop_front();
         compare_field("action", TIME_W'(rsp_chan.action), TIME_W'(want.action));
         compare_field("channel", TIME_W'(rsp_chan.channel), TIME_W'(want.channel));
         compare_field("new_state", TIME_W'(rsp_chan.new_state), TIME_W'(want.new_state));
         compare_field("next_time", rsp_chan.next_time, want.next_time);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) check_response();
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            predicted_responses.push_back(advance_sequencer(req_chan.kind, req_chan.rx_pdu_type,
               req_chan.rx_length, req_chan.rx_target_address, req_chan.now_time,
               req_chan.random_value));
         if (csr_we) apply_write(csr_index, csr_wdata);
      end
      mismatches  <= fail_total;
      outstanding <= predicted_responses.size();
   end

endmodule

/* tb/testbench.sv */
// Top of the advertiser event sequencer testbench: clock, reset, stimulus and verdict.
module testbench
   import baes_pkg::*;
();

   // Event kinds and modes that the package leaves without a name.
   localparam logic [KIND_W-1:0] KIND_RX_TIMEOUT  = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RESERVED    = 3'd7;
   localparam logic [MODE_W-1:0] MODE_CONN_DIRECT = 2'd1;

   localparam int          SETTING_COUNT  = 8;
   localparam int unsigned PHASE_REQUESTS = 85;
   // The slowest request is a realignment; the drain wait covers it.
   localparam int          DRAIN_CYCLES   = 50;
   // Room for about 700 requests, even with the longest stalls, taken several times over.
   localparam int unsigned CYCLE_LIMIT    = 400000;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_RUNS
   } stall_style_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;
   int unsigned          mismatches;
   int unsigned          outstanding;

   baes_req_if req_chan();
   baes_rsp_if rsp_chan();

   // What the stimulus last wrote, so that scan requests can be aimed at the block.
   logic [MODE_W-1:0] cfg_mode;
   logic [ADDR_W-1:0] cfg_address;

   int unsigned burst_left;
   int unsigned requests_sent    = 0;
   int unsigned settings_applied = 0;
   int unsigned scan_hits        = 0;
   int unsigned realign_requests = 0;
   int unsigned cycle_count      = 0;

   always #4 clock = ~clock;

   ble_advertiser_event_sequencer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   baes_response_checker response_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   function automatic logic [ADDR_W-1:0] random_address();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Presents one request and returns at the edge where it is taken. The sender works in
   // bursts: when a burst is used up, valid drops for a random, nonzero gap,
   // so valid never gets two assignments in one time step. Now and then a long burst
   // gives a stretch with no idling on the request side.
   task automatic send_request(
      input logic [KIND_W-1:0]  kind,
      input logic [PTYPE_W-1:0] ptype,
      input logic [LEN_W-1:0]   len,
      input logic [ADDR_W-1:0]  addr,
      input logic [TIME_W-1:0]  now,
      input logic [RND_W-1:0]   rnd
   );
      int unsigned gap;
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         gap = $urandom_range(1, 10);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_chan.valid             <= 1'b1;
      req_chan.kind              <= kind;
      req_chan.rx_pdu_type       <= ptype;
      req_chan.rx_length         <= len;
      req_chan.rx_target_address <= addr;
      req_chan.now_time          <= now;
      req_chan.random_value      <= rnd;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      burst_left--;
      requests_sent++;
      if (kind == KIND_CANCELED || kind == KIND_PASSED) realign_requests++;
   endtask

   // A request of the given kind with every other field random.
   task automatic send_event(input logic [KIND_W-1:0] kind);
      send_request(kind, 4'($urandom), 8'($urandom), random_address(), $urandom, 8'($urandom));
   endtask

   // One register write. Bits above the register's width carry junk, which the block
   // must drop. The write enable stays high when writes follow back to back.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] value, input int width);
      logic [CSR_DAT_W-1:0] keep;
      keep = (48'h1 << width) - 48'h1;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (random_address() & ~keep) | (value & keep);
      @(posedge clock);
   endtask

   // Writes all seven registers with one of several settings. The fixed settings reach the
   // extremes: every mode, a channel count of zero (clamped to one), a zero period, an
   // all-ones period and step, and start times next to the wrap of the time counter.
   task automatic apply_setting(input int n);
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
      logic [TABLE_W-1:0] chan_table;
      logic [ADDR_W-1:0]  addr;
      logic [TIME_W-1:0]  period;
      logic [TIME_W-1:0]  step;
      logic [TIME_W-1:0]  start;
      chan_table = 18'($urandom);
      addr       = random_address();
      period     = $urandom_range(1, 5000);
      step       = $urandom_range(0, 2000);
      start      = $urandom;
      case (n)
         0: begin
            mode  = MODE_CONN_SCAN;
            count = MAX_CHANNELS;
         end
         1: begin
            mode       = MODE_CONN_DIRECT;
            count      = 2'd2;
            chan_table = '1;
            addr       = '1;
            period     = '1;
            step       = '1;
            start      = 32'hffff_fff0;
         end
         2: begin
            mode       = MODE_SCAN;
            count      = 2'd1;
            chan_table = '0;
            addr       = '0;
            period     = '0;
            step       = '0;
            start      = '0;
         end
         3: begin
            mode   = MODE_NONCONN;
            count  = 2'd0;
            period = 32'd1;
            start  = '1;
         end
         4: begin
            mode   = MODE_CONN_SCAN;
            count  = MAX_CHANNELS;
            period = $urandom;
            step   = $urandom;
         end
         5: begin
            mode   = MODE_SCAN;
            count  = 2'd2;
            period = $urandom_range(1, 16);
         end
         6: begin
            mode  = MODE_CONN_DIRECT;
            count = MAX_CHANNELS;
         end
         default: begin
            mode   = MODE_CONN_SCAN;
            count  = 2'd1;
            period = '1;
         end
      endcase
      write_register(CSR_ADV_MODE, CSR_DAT_W'(mode), MODE_W);
      write_register(CSR_CHANNEL_COUNT, CSR_DAT_W'(count), COUNT_W);
      write_register(CSR_CHANNEL_TABLE, CSR_DAT_W'(chan_table), TABLE_W);
      write_register(CSR_OWN_ADDRESS, addr, ADDR_W);
      write_register(CSR_ADV_PERIOD, CSR_DAT_W'(period), TIME_W);
      write_register(CSR_SLOT_STEP, CSR_DAT_W'(step), TIME_W);
      write_register(CSR_START_TIME, CSR_DAT_W'(start), TIME_W);
      csr_we      <= 1'b0;
      cfg_mode    = mode;
      cfg_address = addr;
      settings_applied++;
   endtask

   // Drops valid and waits until every request taken so far has had its response. The
   // checker's count is registered, so the task waits for a clock edge before it looks at it.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // The receiver switches at random between stall styles: always ready,
   // ready three times in four, and alternating runs of ready and stalled cycles.
   initial begin
      stall_style_type style;
      int unsigned     style_left;
      int unsigned     run_left;
      logic            run_level;
      logic            ready_next;
      rsp_chan.ready = 1'b0;
      style_left     = 0;
      run_left       = 0;
      run_level      = 1'b0;
      forever begin
         @(posedge clock);
         if (style_left == 0) begin
            style      = stall_style_type'($urandom_range(0, 2));
            style_left = $urandom_range(50, 300);
         end
         style_left--;
         case (style)
            STALL_NONE:   ready_next = 1'b1;
            STALL_RANDOM: ready_next = ($urandom_range(0, 3) != 0);
            default: begin
               if (run_left == 0) begin
                  run_level = ~run_level;
                  run_left  = $urandom_range(1, 12);
               end
               run_left--;
               ready_next = run_level;
            end
         endcase
         rsp_chan.ready <= ready_next;
      end
   end

   // A hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      int unsigned       phase_end;
      int unsigned       pick;
      logic [PTYPE_W-1:0] ptype;
      logic [LEN_W-1:0]   len;
      logic [ADDR_W-1:0]  addr;
      reset                      = 1'b1;
      csr_we                     = 1'b0;
      csr_index                  = '0;
      csr_wdata                  = '0;
      req_chan.valid             = 1'b0;
      req_chan.kind              = '0;
      req_chan.rx_pdu_type       = '0;
      req_chan.rx_length         = '0;
      req_chan.rx_target_address = '0;
      req_chan.now_time          = '0;
      req_chan.random_value      = '0;
      burst_left                 = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      apply_setting(0);

      // Directed requests. A full slot with a scan request aimed at the block, with all
      // other fields at their lowest and then at their highest.
      send_request(KIND_START, '0, '0, '0, '0, '0);
      send_request(KIND_TX_DONE, '1, '1, '1, '1, '1);
      send_request(KIND_RX_DONE, PDU_SCAN_REQ, SCAN_REQ_LEN, cfg_address, '0, '0);
      send_event(KIND_TX_DONE);
      send_request(KIND_STOP, '0, '0, '0, '0, '0);
      // A scan request one byte short: the block goes idle instead of responding.
      send_event(KIND_START);
      send_event(KIND_TX_DONE);
      send_request(KIND_RX_DONE, PDU_SCAN_REQ, SCAN_REQ_LEN - 8'd1, cfg_address, '1, '1);
      send_request(KIND_STOP, '1, '1, '1, '1, '1);
      // A receive timeout changes nothing in either radio state, nor does the unused kind.
      send_event(KIND_START);
      send_event(KIND_RX_TIMEOUT);
      send_event(KIND_RESERVED);
      send_event(KIND_TX_DONE);
      send_event(KIND_RX_TIMEOUT);
      send_event(KIND_STOP);
      // Realignment with the current time at both ends of its range.
      send_request(KIND_CANCELED, '1, '1, '1, '0, '1);
      send_request(KIND_PASSED, '0, '0, '0, '1, '0);
      // Stops while idle use up the channels of the event and then reload them.
      repeat (3) send_event(KIND_STOP);
      // Radio events while idle, and a second start while sending, are ignored.
      send_event(KIND_TX_DONE);
      send_event(KIND_RX_DONE);
      send_event(KIND_START);
      send_event(KIND_START);
      send_event(KIND_STOP);

      // Random part: one phase per register setting. Most requests form complete
      // advertising slots with random content; the rest are realignments and noise.
      for (int phase = 0; phase < SETTING_COUNT; phase++) begin
         if (phase != 0) begin
            wait_for_drain();
            apply_setting(phase);
         end
         phase_end = requests_sent + PHASE_REQUESTS;
         while (requests_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               send_event(KIND_START);
               if ($urandom_range(0, 9) == 0) send_event(KIND_RX_TIMEOUT);
               send_event(KIND_TX_DONE);
               if (cfg_mode != MODE_NONCONN) begin
                  // Half the scan requests are aimed at the block; the rest miss it by
                  // one field, the address by a single bit.
                  ptype = PDU_SCAN_REQ;
                  len   = SCAN_REQ_LEN;
                  addr  = cfg_address;
                  case ($urandom_range(0, 5))
                     0, 1, 2: scan_hits++;
                     3:       ptype = PDU_SCAN_REQ ^ 4'($urandom_range(1, 15));
                     4:       len = SCAN_REQ_LEN ^ 8'($urandom_range(1, 255));
                     default: addr = cfg_address ^ (48'h1 << $urandom_range(0, 47));
                  endcase
                  send_request(KIND_RX_DONE, ptype, len, addr, $urandom, 8'($urandom));
                  if (ptype == PDU_SCAN_REQ && len == SCAN_REQ_LEN && addr == cfg_address)
                     send_event(KIND_TX_DONE);
               end
               send_event(KIND_STOP);
            end else if (pick < 80) begin
               send_event(($urandom_range(0, 1) == 0) ? KIND_CANCELED : KIND_PASSED);
            end else begin
               repeat ($urandom_range(1, 4)) send_event(3'($urandom_range(0, 7)));
            end
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests under %0d register settings: %0d realignments,",
               requests_sent, settings_applied, realign_requests);
      $display("%0d scan requests carrying the own address, %0d mismatches",
               scan_hits, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* ble_advertiser_event_sequencer_unit.f */
src/baes_pkg.sv
src/baes_if.sv
src/ble_advertiser_event_sequencer_unit.sv
tb/baes_response_checker.sv
tb/testbench.sv
